// ===== design/fpas_pkg.sv =====
// Shared constants and types for the five-point average stencil.
// No dependencies; compiled first.
package fpas_pkg;

  localparam int CFG_BITS       = 9;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam int RESET_DIM  = 150;
  localparam int MIN_DIM    = 3;
  localparam int POS_BITS   = 8;
  localparam int MEAN_TERMS = 5;

  localparam int DEFAULT_MAX_DIM     = 256;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  typedef struct packed {
    logic                has_up;
    logic                has_cur;
    logic                interior;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
  } pos_flags_t;

endpackage

// ===== design/fpas_if.sv =====
// Valid/ready channel interfaces for the stencil: sample beats in, result beats out.
// Depends on fpas_pkg.
interface fpas_in_if import fpas_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fpas_out_if import fpas_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] smoothed;
  logic [POS_BITS-1:0]    out_row;
  logic [POS_BITS-1:0]    out_col;
  logic                   last;

  modport source (output valid, output smoothed, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input smoothed, input out_row, input out_col,
                input last, output ready);
endinterface

// ===== design/fpas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fpas_raster.sv =====
// Raster position tracker: row/column counters, dimension clamping and
// per-point border/interior flags. Depends on fpas_pkg.
module fpas_raster import fpas_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM,
  localparam int AW = $clog2(MAX_DIM)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [CFG_BITS-1:0] grid_width,
  input  logic [CFG_BITS-1:0] grid_height,
  output pos_flags_t          flags,
  output logic [AW-1:0]       col,
  output logic [AW-1:0]       col_right
);

  localparam int DW = AW + 1;
  localparam int CW = (DW > CFG_BITS) ? DW : CFG_BITS;

  logic [AW-1:0] row_count, row_count_next;
  logic [AW-1:0] col_count, col_count_next;
  logic [AW-1:0] r0, c0;
  logic [DW-1:0] w, h, row_step, col_step, row_inc;
  logic          col_wrap, row_end;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
    logic [CW-1:0] e;
    logic [CW-1:0] r;
    e = CW'(v);
    if (e < CW'(MIN_DIM)) begin
      r = CW'(MIN_DIM);
    end else if (e > CW'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = e;
    end
    return DW'(r);
  endfunction

  always_comb begin
    w = clamp_dim(grid_width);
    h = clamp_dim(grid_height);
    // counters past a shrunken dimension start a new row / grid
    col_wrap = DW'(col_count) >= w;
    c0       = col_wrap ? '0 : col_count;
    row_step = col_wrap ? DW'(row_count) + DW'(1) : DW'(row_count);
    r0       = (row_step >= h) ? '0 : row_step[AW-1:0];

    col_step = DW'(c0) + DW'(1);
    row_inc  = DW'(r0) + DW'(1);
    row_end  = col_step >= w;

    col_count_next = row_end ? '0 : col_step[AW-1:0];
    if (!row_end) begin
      row_count_next = r0;
    end else if (row_inc >= h) begin
      row_count_next = '0;
    end else begin
      row_count_next = row_inc[AW-1:0];
    end

    flags.has_up   = r0 != '0;
    flags.has_cur  = DW'(r0) == (h - DW'(1));
    flags.interior = (r0 >= AW'(2)) && (c0 != '0) && !row_end;
    flags.row      = POS_BITS'(r0);
    flags.col      = POS_BITS'(c0);

    col       = c0;
    col_right = col_step[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (advance) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

// ===== design/fpas_emit.sv =====
// Result stage: divide-by-five of the neighborhood sum, up to two result
// beats per sample, output register. Depends on fpas_pkg and fpas_if.
module fpas_emit import fpas_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
  localparam int MAG_BITS = SAMPLE_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [MAG_BITS-1:0]    mag,
  input  logic                   neg,
  input  logic [SAMPLE_BITS-1:0] up_raw,
  input  logic [SAMPLE_BITS-1:0] cur,
  input  pos_flags_t             flags,
  output logic                   ready,
  fpas_out_if.source             filtered
);

  // floor(m / 5) == (m * ceil(2^(N+3) / 5)) >> (N+3) for any N-bit m
  localparam int SHIFT     = MAG_BITS + 3;
  localparam int PROD_BITS = 2 * MAG_BITS + 1;
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << SHIFT) + 64'(MEAN_TERMS - 1)) / 64'(MEAN_TERMS);
  localparam logic [MAG_BITS:0] DIV_MAGIC = MAGIC_FULL[MAG_BITS:0];

  logic                   held, phase;
  logic [MAG_BITS-1:0]    h_mag;
  logic                   h_neg;
  logic [SAMPLE_BITS-1:0] h_up, h_cur;
  pos_flags_t             h_flags;

  logic                   out_valid, out_last;
  logic [SAMPLE_BITS-1:0] out_smoothed;
  logic [POS_BITS-1:0]    out_row, out_col;

  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS-1:0] quot, mean, up_val;
  logic                   piece_up, piece_last, empty, out_free, emit, done;

  always_comb begin
    prod       = PROD_BITS'(h_mag) * PROD_BITS'(DIV_MAGIC);
    quot       = prod[SHIFT +: SAMPLE_BITS];
    mean       = h_neg ? -quot : quot;
    up_val     = h_flags.interior ? mean : h_up;
    piece_up   = h_flags.has_up && !phase;
    piece_last = piece_up ? !h_flags.has_cur : 1'b1;
    empty      = !h_flags.has_up && !h_flags.has_cur;
    out_free   = !out_valid || filtered.ready;
    emit       = held && !empty && out_free;
    done       = held && (empty || (out_free && piece_last));
    ready      = !held || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        held <= 1'b1;
      end else if (done) begin
        held <= 1'b0;
      end
      if (load) begin
        phase <= 1'b0;
      end else if (emit && !piece_last) begin
        phase <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_mag   <= mag;
      h_neg   <= neg;
      h_up    <= up_raw;
      h_cur   <= cur;
      h_flags <= flags;
    end
    if (emit) begin
      out_smoothed <= piece_up ? up_val : h_cur;
      out_row      <= piece_up ? h_flags.row - POS_BITS'(1) : h_flags.row;
      out_col      <= h_flags.col;
      out_last     <= piece_last;
    end
  end

  assign filtered.valid    = out_valid;
  assign filtered.smoothed = out_smoothed;
  assign filtered.out_row  = out_row;
  assign filtered.out_col  = out_col;
  assign filtered.last     = out_last;

endmodule

// ===== design/five_point_average_stencil.sv =====
// Top level of the five-point average stencil: config registers, row stores,
// sum stage. Depends on fpas_pkg, fpas_if, fpas_ram, fpas_raster, fpas_emit.
//
//   channel    dir  handshake        payload
//   heights    in   valid/ready      sample
//   filtered   out  valid/ready      smoothed, out_row, out_col, last
//   wr_*       in   wr_en only       wr_index, wr_data
//
// One sample beat per clock while filtered does not stall. A sample's first result
// beat reaches filtered through the row-store read at acceptance, the emit hold
// register and the result register. Last-row samples give two result beats, so
// there the output port sets the rate. First-row samples give no beat.
// Synchronous reset clears counters and valids; the row stores need no clear.
// A filtered stall fills the result, hold and s1 registers before heights.ready drops.
module five_point_average_stencil import fpas_pkg::*; #(
  parameter int MAX_DIM     = DEFAULT_MAX_DIM,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_BITS-1:0]       wr_data,
  fpas_in_if.sink                   heights,
  fpas_out_if.source                filtered
);

  localparam int AW       = $clog2(MAX_DIM);
  localparam int SUM_BITS = SAMPLE_BITS + 3;
  localparam int MAG_BITS = SAMPLE_BITS + 2;

  logic [CFG_BITS-1:0] grid_width, grid_height;

  logic                   accept, s1_valid, s1_adv, emit_ready;
  logic [SAMPLE_BITS-1:0] s1_cur, left;
  pos_flags_t             s1_flags, flags;
  logic [AW-1:0]          s1_col, col, col_right;

  logic [SAMPLE_BITS-1:0]     ra_c, ra_n, rta_c;
  logic signed [SUM_BITS-1:0] sum;
  logic                       neg;
  logic [MAG_BITS-1:0]        mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_BITS'(RESET_DIM);
      grid_height <= CFG_BITS'(RESET_DIM);
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_WIDTH:  grid_width  <= wr_data;
        REG_GRID_HEIGHT: grid_height <= wr_data;
        default: ;
      endcase
    end
  end

  assign s1_adv        = s1_valid && emit_ready;
  assign heights.ready = !s1_valid || s1_adv;
  assign accept        = heights.valid && heights.ready;

  fpas_raster #(.MAX_DIM(MAX_DIM)) u_raster (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .grid_width (grid_width),
    .grid_height(grid_height),
    .flags      (flags),
    .col        (col),
    .col_right  (col_right)
  );

  // row above, read at this column and the next; row two above, this column
  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM)) u_row_above (
    .clk(clk), .wr_en(s1_adv), .wr_addr(s1_col), .wr_data(s1_cur),
    .rd_en(accept), .rd_addr(col), .rd_data(ra_c)
  );

  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM)) u_row_above_right (
    .clk(clk), .wr_en(s1_adv), .wr_addr(s1_col), .wr_data(s1_cur),
    .rd_en(accept), .rd_addr(col_right), .rd_data(ra_n)
  );

  fpas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM)) u_row_two_above (
    .clk(clk), .wr_en(s1_adv), .wr_addr(s1_col), .wr_data(ra_c),
    .rd_en(accept), .rd_addr(col), .rd_data(rta_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // left neighbor = previous column's row-above value
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur   <= heights.sample;
      s1_flags <= flags;
      s1_col   <= col;
    end
    if (s1_adv) begin
      left <= ra_c;
    end
  end

  always_comb begin
    sum = SUM_BITS'($signed(rta_c)) + SUM_BITS'($signed(left))
        + SUM_BITS'($signed(ra_c)) + SUM_BITS'($signed(ra_n))
        + SUM_BITS'($signed(s1_cur));
    neg = sum[SUM_BITS-1];
    mag = MAG_BITS'(neg ? -sum : sum);
  end

  fpas_emit #(.SAMPLE_BITS(SAMPLE_BITS)) u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (s1_adv),
    .mag     (mag),
    .neg     (neg),
    .up_raw  (ra_c),
    .cur     (s1_cur),
    .flags   (s1_flags),
    .ready   (emit_ready),
    .filtered(filtered)
  );

`ifndef SYNTHESIS
  a_interior_has_up: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_flags.interior |-> s1_flags.has_up)
    else $error("interior point without a row above");

  a_store_data_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> $stable(ra_c) && $stable(rta_c) && $stable(ra_n))
    else $error("row store data changed during stall");

  a_second_beat_follows: assert property (@(posedge clk) disable iff (rst)
    filtered.valid && filtered.ready && !filtered.last |=> filtered.valid)
    else $error("second result beat missing");
`endif

endmodule
